>>> rtl/core/rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit.
// Included by files that carry concurrent assertions. It has no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational arithmetic unit: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational arithmetic unit: assertion failed");
`else
`define RAU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 32;
   localparam int FIELD_W               = 32;
   localparam int KIND_W                = 2;
   localparam int MAG_W                 = 64;
   localparam int DEN_W                 = 63;
   localparam int STATUS_W              = 2;
   localparam int SHIFT_W               = 7;
   localparam int DIV_CNT_W             = 6;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_ZERO_DEN = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MSEL_T1 = 2'd0,
      MSEL_T2 = 2'd1,
      MSEL_T3 = 2'd2
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_T1,
      ST_MUL_T2,
      ST_MUL_T3,
      ST_COMBINE,
      ST_GCD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        combine;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic skip;
      logic gcd_done;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/core/rau_req_if.sv
// Request channel of the rational arithmetic unit: valid, ready and one operand item.
// Depends on rau_pkg for the field widths.
`default_nettype none

interface rau_req_if;
   logic                                valid;
   logic                                ready;
   logic [rau_pkg::KIND_W-1:0]          kind;
   logic signed [rau_pkg::FIELD_W-1:0]  first_num;
   logic signed [rau_pkg::FIELD_W-1:0]  first_den;
   logic signed [rau_pkg::FIELD_W-1:0]  second_num;
   logic signed [rau_pkg::FIELD_W-1:0]  second_den;

   modport source (output valid, kind, first_num, first_den, second_num, second_den,
                   input ready);
   modport sink   (input valid, kind, first_num, first_den, second_num, second_den,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/rau_rsp_if.sv
// Response channel of the rational arithmetic unit: valid, ready and one result item.
// Depends on rau_pkg for the field widths.
`default_nettype none

interface rau_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rau_pkg::MAG_W-1:0]    result_num;
   logic [rau_pkg::DEN_W-1:0]           result_den;
   logic [rau_pkg::STATUS_W-1:0]        status;

   modport source (output valid, result_num, result_den, status, input ready);
   modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand capture, shared multiplier,
// binary gcd, dual restoring divider and output register. Depends on rau_pkg.
`default_nettype none

module rau_datapath #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire rau_pkg::dp_cmd_type               cmd,
   output rau_pkg::dp_status_type                 stat,
   input  wire logic [rau_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [rau_pkg::FIELD_W-1:0]       req_first_num,
   input  wire logic [rau_pkg::FIELD_W-1:0]       req_first_den,
   input  wire logic [rau_pkg::FIELD_W-1:0]       req_second_num,
   input  wire logic [rau_pkg::FIELD_W-1:0]       req_second_den,
   output logic [rau_pkg::MAG_W-1:0]              rsp_result_num,
   output logic [rau_pkg::DEN_W-1:0]              rsp_result_den,
   output logic [rau_pkg::STATUS_W-1:0]           rsp_status
);
   import rau_pkg::*;

   localparam int OP_AN = 0;
   localparam int OP_AD = 1;
   localparam int OP_BN = 2;
   localparam int OP_BD = 3;

   logic [3:0][OPERAND_WIDTH-1:0] raw;
   logic [3:0][OPERAND_WIDTH-1:0] mag;
   logic [3:0]                    neg;

   kind_type                      kind_ff;
   logic [3:0][OPERAND_WIDTH-1:0] mag_ff;
   logic [3:0]                    neg_ff;
   status_type                    early_ff, early_in;
   logic                          special_ff, special_in;

   logic [OPERAND_WIDTH-1:0]      mul_a, mul_b;
   logic                          mul_neg;
   logic [2*OPERAND_WIDTH-1:0]    product;
   logic [MAG_W-1:0]              t1_ff, t2_ff, t3_ff;
   logic                          t1_neg_ff, t2_neg_ff, t3_neg_ff;

   logic                          t2_neg_eff;
   logic [MAG_W-1:0]              n_mag_in, d_mag_in;
   logic                          n_neg_in, d_neg_in;
   logic [MAG_W-1:0]              n_mag_ff, d_mag_ff;
   logic                          res_neg_ff, zero_ff;

   logic [MAG_W-1:0]              x_ff, y_ff, x_in, y_in;
   logic [SHIFT_W-1:0]            k_ff, k_in;

   logic [MAG_W-1:0]              g_ff;
   logic [MAG_W-1:0]              qn_ff, qd_ff, rn_ff, rd_ff;
   logic [MAG_W:0]                rn_next, rd_next;
   logic                          ge_n, ge_d;
   logic [DIV_CNT_W-1:0]          cnt_ff;

   // Operand decode: the low OPERAND_WIDTH bits as two's complement, split into
   // sign and magnitude. The most negative value keeps its full magnitude.
   assign raw[OP_AN] = req_first_num[OPERAND_WIDTH-1:0];
   assign raw[OP_AD] = req_first_den[OPERAND_WIDTH-1:0];
   assign raw[OP_BN] = req_second_num[OPERAND_WIDTH-1:0];
   assign raw[OP_BD] = req_second_den[OPERAND_WIDTH-1:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg[i] = raw[i][OPERAND_WIDTH-1];
         mag[i] = neg[i] ? (~raw[i] + 1'b1) : raw[i];
      end
   end

   always_comb begin
      special_in = 1'b1;
      early_in   = STATUS_OK;
      if (mag[OP_AD] == '0 || mag[OP_BD] == '0) begin
         early_in = STATUS_ZERO_DEN;
      end else if (kind_type'(req_kind) == KIND_DIV && mag[OP_BN] == '0) begin
         early_in = STATUS_DIV_ZERO;
      end else begin
         special_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= kind_type'(req_kind);
         mag_ff     <= mag;
         neg_ff     <= neg;
         early_ff   <= early_in;
         special_ff <= special_in;
      end
   end

   // One shared multiplier, three passes.
   always_comb begin
      case (cmd.mul_sel)
         MSEL_T1: begin
            mul_a   = mag_ff[OP_AN];
            mul_b   = (kind_ff == KIND_MUL) ? mag_ff[OP_BN] : mag_ff[OP_BD];
            mul_neg = neg_ff[OP_AN] ^ ((kind_ff == KIND_MUL) ? neg_ff[OP_BN] : neg_ff[OP_BD]);
         end
         MSEL_T2: begin
            mul_a   = mag_ff[OP_AD];
            mul_b   = mag_ff[OP_BN];
            mul_neg = neg_ff[OP_AD] ^ neg_ff[OP_BN];
         end
         MSEL_T3: begin
            mul_a   = mag_ff[OP_AD];
            mul_b   = mag_ff[OP_BD];
            mul_neg = neg_ff[OP_AD] ^ neg_ff[OP_BD];
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_T1: begin
               t1_ff     <= MAG_W'(product);
               t1_neg_ff <= mul_neg;
            end
            MSEL_T2: begin
               t2_ff     <= MAG_W'(product);
               t2_neg_ff <= mul_neg;
            end
            default: begin
               t3_ff     <= MAG_W'(product);
               t3_neg_ff <= mul_neg;
            end
         endcase
      end
   end

   // Cross products into numerator and denominator, sign and magnitude.
   always_comb begin
      t2_neg_eff = t2_neg_ff ^ (kind_ff == KIND_SUB);
      n_mag_in   = t1_ff;
      n_neg_in   = t1_neg_ff;
      d_mag_in   = t3_ff;
      d_neg_in   = t3_neg_ff;
      case (kind_ff)
         KIND_ADD, KIND_SUB: begin
            if (t1_neg_ff == t2_neg_eff) begin
               n_mag_in = t1_ff + t2_ff;
            end else if (t1_ff >= t2_ff) begin
               n_mag_in = t1_ff - t2_ff;
            end else begin
               n_mag_in = t2_ff - t1_ff;
               n_neg_in = t2_neg_eff;
            end
         end
         KIND_DIV: begin
            d_mag_in = t2_ff;
            d_neg_in = t2_neg_ff;
         end
         default: begin
         end
      endcase
   end

   // Binary gcd: strip common factors of two into k, halve whichever value alone
   // is even, else subtract the smaller from the larger until both are equal.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else if (x_ff > y_ff) begin
         x_in = x_ff - y_ff;
      end else begin
         y_in = y_ff - x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         n_mag_ff   <= n_mag_in;
         d_mag_ff   <= d_mag_in;
         res_neg_ff <= n_neg_in ^ d_neg_in;
         zero_ff    <= (n_mag_in == '0);
         x_ff       <= n_mag_in;
         y_ff       <= d_mag_in;
         k_ff       <= '0;
      end else if (cmd.gcd_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         k_ff <= k_in;
      end
   end

   // Both quotients by the gcd share one divisor and one bit per cycle.
   assign rn_next = {rn_ff, qn_ff[MAG_W-1]};
   assign rd_next = {rd_ff, qd_ff[MAG_W-1]};
   assign ge_n    = rn_next >= {1'b0, g_ff};
   assign ge_d    = rd_next >= {1'b0, g_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         g_ff   <= x_ff << k_ff;
         qn_ff  <= n_mag_ff;
         qd_ff  <= d_mag_ff;
         rn_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rn_ff  <= ge_n ? MAG_W'(rn_next - {1'b0, g_ff}) : rn_next[MAG_W-1:0];
         rd_ff  <= ge_d ? MAG_W'(rd_next - {1'b0, g_ff}) : rd_next[MAG_W-1:0];
         qn_ff  <= {qn_ff[MAG_W-2:0], ge_n};
         qd_ff  <= {qd_ff[MAG_W-2:0], ge_d};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign stat.skip     = special_ff | zero_ff;
   assign stat.gcd_done = (x_ff == y_ff);
   assign stat.div_last = (cnt_ff == '1);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (special_ff) begin
            rsp_result_num <= '0;
            rsp_result_den <= DEN_W'(1);
            rsp_status     <= early_ff;
         end else if (zero_ff) begin
            rsp_result_num <= '0;
            rsp_result_den <= DEN_W'(1);
            rsp_status     <= STATUS_OK;
         end else if (!res_neg_ff && qn_ff[MAG_W-1]) begin
            rsp_result_num <= '0;
            rsp_result_den <= DEN_W'(1);
            rsp_status     <= STATUS_OVERFLOW;
         end else begin
            rsp_result_num <= res_neg_ff ? (~qn_ff + 1'b1) : qn_ff;
            rsp_result_den <= qd_ff[DEN_W-1:0];
            rsp_status     <= STATUS_OK;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences the datapath and owns
// the handshakes. Depends on rau_pkg.
`default_nettype none

module rau_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rau_pkg::dp_status_type stat,
   output rau_pkg::dp_cmd_type         cmd
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MSEL_T1;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_T1;
            end
         end
         ST_MUL_T1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T1;
            state_in    = ST_MUL_T2;
         end
         ST_MUL_T2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T2;
            state_in    = ST_MUL_T3;
         end
         ST_MUL_T3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T3;
            state_in    = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_GCD;
         end
         ST_GCD: begin
            if (stat.skip) begin
               state_in = ST_FINISH;
            end else if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller, datapath and assertions.
// Depends on rau_pkg, rau_req_if, rau_rsp_if, rau_ctrl, rau_datapath and the defines header.
//
// Usage. Each item on req_chan holds two signed fractions and an operation
// (add, subtract, multiply, divide). Each item yields exactly one item on
// rsp_chan: the result reduced to lowest terms with a positive denominator,
// plus a status (ok, divide by a zero fraction, zero input denominator, or
// overflow when the reduced positive numerator does not fit a signed 64-bit value).
// Only the low OPERAND_WIDTH bits of each operand are used.
// Sequence: the item is captured, the cross products are formed on the shared
// multiplier and combined, then a binary gcd runs at one step per cycle, then
// the divider forms both reduced terms at once, then the result moves into the
// output register. Items that hit a special case, or whose numerator is zero,
// skip the gcd and the divider. One item is in flight at a time; the gcd loop
// and the divider set the throughput.
// The result waits in an output register, so a new item is accepted as soon
// as the previous one has been moved there, even while the receiver stalls.
// If the receiver still stalls when the next result is ready, the block
// holds that result and accepts nothing until the register frees up.
// Reset (synchronous, active high) returns the controller to idle and drops
// any pending result. No state is kept between items.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rau_req_if.sink  req_chan,
   rau_rsp_if.source rsp_chan
);
   import rau_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_chan.kind),
      .req_first_num  (req_chan.first_num),
      .req_first_den  (req_chan.first_den),
      .req_second_num (req_chan.second_num),
      .req_second_den (req_chan.second_den),
      .rsp_result_num (rsp_chan.result_num),
      .rsp_result_den (rsp_chan.result_den),
      .rsp_status     (rsp_chan.status)
   );

   // A delivered denominator is never zero.
   `RAU_ASSERT_SAME(a_den_nonzero, clock, reset, rsp_chan.valid, rsp_chan.result_den != '0)
   // Any error status comes with the result 0/1.
   `RAU_ASSERT_SAME(a_error_zero, clock, reset, rsp_chan.valid && rsp_chan.status != STATUS_OK, rsp_chan.result_num == '0 && rsp_chan.result_den == DEN_W'(1))
   // In the cycle after accepting an item the block is busy.
   `RAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // A new result is only loaded when the output register is free or draining.
   `RAU_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !rsp_chan.valid || rsp_chan.ready)

endmodule

`default_nettype wire
